// File: hw/rtl/c3lbf_pkg.sv
package c3lbf_pkg;

   localparam int PIX_W      = 8;
   localparam int TAPS       = 9;
   localparam int CSR_DATA_W = 48;
   localparam int CSR_IDX_W  = 3;
   localparam int KTM_W      = 48;
   localparam int KBR_W      = 24;
   localparam int SHIFT_W    = 5;
   localparam int DIM_W      = 12;

   localparam int PROD_W = 17;
   localparam int RSUM_W = PROD_W + 2;
   localparam int ACC_W  = RSUM_W + 2;

   typedef logic [CSR_IDX_W-1:0]  csr_index_type;
   typedef logic [CSR_DATA_W-1:0] csr_data_type;
   typedef logic [PIX_W-1:0]      pixel_type;
   typedef logic [TAPS-1:0][PIX_W-1:0] window_type;

   localparam csr_index_type CSR_KERNEL_TOP_MID = 3'd0;
   localparam csr_index_type CSR_KERNEL_BOTTOM  = 3'd1;
   localparam csr_index_type CSR_RIGHT_SHIFT    = 3'd2;
   localparam csr_index_type CSR_MAGNITUDE      = 3'd3;
   localparam csr_index_type CSR_IMAGE_HEIGHT   = 3'd4;
   localparam csr_index_type CSR_IMAGE_WIDTH    = 3'd5;

   typedef struct packed {
      logic shift_en;
      logic col0;
   } win_ctrl_type;

endpackage

// File: hw/rtl/conv3x3_line_buffer_filter_unit.sv
// Path: an accepted request passes the request, product, row-sum, sum and output registers.
// Throughput: one request per cycle unless the output stalls, set by the single read and
// write port of each line store; steps in row 0 or column 0 give no output.
// Reset: counters, window, pipeline valids and configuration registers return to
// their reset values synchronously; line store contents stay undefined until written.
module conv3x3_line_buffer_filter_unit #(
   parameter int LINE_STORE_DEPTH = 2048,
   parameter int MAX_ROWS         = 4095
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  c3lbf_pkg::pixel_type       req_pixel_in,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output c3lbf_pkg::pixel_type       rsp_pixel_out,
   output logic                       rsp_last_of_image,
   input  logic                       csr_write,
   input  c3lbf_pkg::csr_index_type   csr_index,
   input  c3lbf_pkg::csr_data_type    csr_wdata
);
   import c3lbf_pkg::*;

   localparam int ADDR_W = $clog2(LINE_STORE_DEPTH);
   localparam int COL_W  = $clog2(LINE_STORE_DEPTH + 1);
   localparam int ROW_W  = $clog2(MAX_ROWS + 1);
   localparam int WC_W   = (COL_W > DIM_W) ? COL_W : DIM_W;
   localparam int HC_W   = (ROW_W > DIM_W) ? ROW_W : DIM_W;

   logic [KTM_W-1:0]   kernel_top_mid_ff;
   logic [KBR_W-1:0]   kernel_bottom_ff;
   logic [SHIFT_W-1:0] right_shift_ff;
   logic               magnitude_ff;
   logic [DIM_W-1:0]   height_ff;
   logic [DIM_W-1:0]   width_ff;
   logic               restart;

   logic [WC_W-1:0]  eff_w_wide;
   logic [HC_W-1:0]  eff_h_wide;
   logic [COL_W-1:0] eff_w;
   logic [ROW_W-1:0] eff_h;

   logic [COL_W-1:0] col_ff;
   logic [ROW_W-1:0] row_ff;

   logic      accept;
   logic      in_col;
   logic      row_last;
   pixel_type newpix;

   logic              s1_valid_ff;
   logic [ADDR_W-1:0] s1_addr_ff;
   pixel_type         s1_newpix_ff;
   logic              s1_inside_ff;
   logic              s1_top_en_ff;
   logic              s1_mid_en_ff;
   logic              s1_col0_ff;
   logic              s1_emit_ff;
   logic              s1_last_ff;
   logic              s1_adv;

   pixel_type    rd_older;
   pixel_type    rd_newer;
   pixel_type    col_top;
   pixel_type    col_mid;
   logic         lb_wr_en;
   win_ctrl_type win_ctrl;
   window_type   win_next;
   logic         mac_stall;

   assign restart = csr_write &&
      (csr_index == CSR_IMAGE_HEIGHT || csr_index == CSR_IMAGE_WIDTH);

   always_ff @(posedge clock) begin
      if (reset) begin
         kernel_top_mid_ff <= '0;
         kernel_bottom_ff  <= '0;
         right_shift_ff    <= '0;
         magnitude_ff      <= 1'b0;
         height_ff         <= DIM_W'(1);
         width_ff          <= DIM_W'(1);
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_KERNEL_TOP_MID: kernel_top_mid_ff <= csr_wdata[KTM_W-1:0];
            CSR_KERNEL_BOTTOM:  kernel_bottom_ff  <= csr_wdata[KBR_W-1:0];
            CSR_RIGHT_SHIFT:    right_shift_ff    <= csr_wdata[SHIFT_W-1:0];
            CSR_MAGNITUDE:      magnitude_ff      <= csr_wdata[0];
            CSR_IMAGE_HEIGHT:   height_ff         <= csr_wdata[DIM_W-1:0];
            CSR_IMAGE_WIDTH:    width_ff          <= csr_wdata[DIM_W-1:0];
            default: ;
         endcase
      end
   end

   // zero acts as one, oversize clamps to the limit
   always_comb begin
      priority if (width_ff == '0) begin
         eff_w_wide = WC_W'(1);
      end else if (WC_W'(width_ff) > WC_W'(LINE_STORE_DEPTH)) begin
         eff_w_wide = WC_W'(LINE_STORE_DEPTH);
      end else begin
         eff_w_wide = WC_W'(width_ff);
      end
      priority if (height_ff == '0) begin
         eff_h_wide = HC_W'(1);
      end else if (HC_W'(height_ff) > HC_W'(MAX_ROWS)) begin
         eff_h_wide = HC_W'(MAX_ROWS);
      end else begin
         eff_h_wide = HC_W'(height_ff);
      end
   end

   assign eff_w = COL_W'(eff_w_wide);
   assign eff_h = ROW_W'(eff_h_wide);

   assign accept   = req_valid && !req_stall;
   assign in_col   = col_ff < eff_w;
   assign row_last = row_ff == eff_h;
   assign newpix   = (!row_last && in_col) ? req_pixel_in : '0;

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         if (!in_col) begin
            col_ff <= '0;
            row_ff <= row_last ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_ff <= col_ff + COL_W'(1);
         end
      end
   end

   // the write for a column lands before the next read of that column
   assign s1_adv    = !s1_emit_ff || !mac_stall;
   assign req_stall = s1_valid_ff && !s1_adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_addr_ff   <= col_ff[ADDR_W-1:0];
         s1_newpix_ff <= newpix;
         s1_inside_ff <= in_col;
         s1_top_en_ff <= in_col && (row_ff > ROW_W'(1));
         s1_mid_en_ff <= in_col && (row_ff != '0);
         s1_col0_ff   <= col_ff == '0;
         s1_emit_ff   <= (row_ff != '0) && (col_ff != '0);
         s1_last_ff   <= row_last && !in_col;
      end
   end

   c3lbf_line_store #(
      .DEPTH (LINE_STORE_DEPTH)
   ) u_line_store (
      .clock    (clock),
      .rd_en    (accept && in_col),
      .rd_addr  (col_ff[ADDR_W-1:0]),
      .rd_older (rd_older),
      .rd_newer (rd_newer),
      .wr_en    (lb_wr_en),
      .wr_addr  (s1_addr_ff),
      .wr_older (col_mid),
      .wr_newer (s1_newpix_ff)
   );

   assign col_top  = s1_top_en_ff ? rd_older : '0;
   assign col_mid  = s1_mid_en_ff ? rd_newer : '0;
   assign lb_wr_en = s1_valid_ff && s1_adv && s1_inside_ff;

   assign win_ctrl.shift_en = s1_valid_ff && s1_adv;
   assign win_ctrl.col0     = s1_col0_ff;

   c3lbf_window u_window (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (win_ctrl),
      .col_top  (col_top),
      .col_mid  (col_mid),
      .col_new  (s1_newpix_ff),
      .win_next (win_next)
   );

   c3lbf_mac u_mac (
      .clock             (clock),
      .reset             (reset),
      .in_valid          (s1_valid_ff && s1_emit_ff),
      .in_stall          (mac_stall),
      .in_window         (win_next),
      .in_last           (s1_last_ff),
      .kernel_top_mid    (kernel_top_mid_ff),
      .kernel_bottom     (kernel_bottom_ff),
      .right_shift       (right_shift_ff),
      .magnitude_mode    (magnitude_ff),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_pixel_out     (rsp_pixel_out),
      .rsp_last_of_image (rsp_last_of_image)
   );

   a_col_in_range: assert property (@(posedge clock) disable iff (reset)
      col_ff <= eff_w)
      else $error("column counter beyond image width");

   a_row_in_range: assert property (@(posedge clock) disable iff (reset)
      row_ff <= eff_h)
      else $error("row counter beyond image height");

   a_emit_not_col0: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_emit_ff |-> !s1_col0_ff)
      else $error("output request at column zero");

   a_last_is_pad: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_last_ff |-> !s1_inside_ff && s1_emit_ff)
      else $error("last flag outside the final padding step");

endmodule

// File: hw/rtl/c3lbf_line_store.sv
module c3lbf_line_store #(
   parameter int DEPTH = 2048,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic                clock,
   input  logic                rd_en,
   input  logic [ADDR_W-1:0]   rd_addr,
   output c3lbf_pkg::pixel_type rd_older,
   output c3lbf_pkg::pixel_type rd_newer,
   input  logic                wr_en,
   input  logic [ADDR_W-1:0]   wr_addr,
   input  c3lbf_pkg::pixel_type wr_older,
   input  c3lbf_pkg::pixel_type wr_newer
);
   import c3lbf_pkg::*;

   pixel_type older_mem [DEPTH];
   pixel_type newer_mem [DEPTH];
   pixel_type rd_older_ff;
   pixel_type rd_newer_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         older_mem[wr_addr] <= wr_older;
         newer_mem[wr_addr] <= wr_newer;
      end
   end

   // hold read data until the next request is read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_older_ff <= older_mem[rd_addr];
         rd_newer_ff <= newer_mem[rd_addr];
      end
   end

   assign rd_older = rd_older_ff;
   assign rd_newer = rd_newer_ff;

endmodule

// File: hw/rtl/c3lbf_window.sv
module c3lbf_window (
   input  logic                   clock,
   input  logic                   reset,
   input  c3lbf_pkg::win_ctrl_type ctrl,
   input  c3lbf_pkg::pixel_type    col_top,
   input  c3lbf_pkg::pixel_type    col_mid,
   input  c3lbf_pkg::pixel_type    col_new,
   output c3lbf_pkg::window_type   win_next
);
   import c3lbf_pkg::*;

   window_type win_ff;
   window_type win_in;

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         win_in[3*r]     = ctrl.col0 ? '0 : win_ff[3*r+1];
         win_in[3*r + 1] = ctrl.col0 ? '0 : win_ff[3*r+2];
      end
      win_in[2] = col_top;
      win_in[5] = col_mid;
      win_in[8] = col_new;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= '0;
      end else if (ctrl.shift_en) begin
         win_ff <= win_in;
      end
   end

   assign win_next = win_in;

endmodule

// File: hw/rtl/c3lbf_mac.sv
module c3lbf_mac (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_stall,
   input  c3lbf_pkg::window_type         in_window,
   input  logic                          in_last,
   input  logic [c3lbf_pkg::KTM_W-1:0]   kernel_top_mid,
   input  logic [c3lbf_pkg::KBR_W-1:0]   kernel_bottom,
   input  logic [c3lbf_pkg::SHIFT_W-1:0] right_shift,
   input  logic                          magnitude_mode,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output c3lbf_pkg::pixel_type          rsp_pixel_out,
   output logic                          rsp_last_of_image
);
   import c3lbf_pkg::*;

   localparam int KALL_W = KTM_W + KBR_W;

   logic [KALL_W-1:0] kernel_all;

   logic p_valid_ff, r_valid_ff, s_valid_ff, rsp_valid_ff;
   logic p_last_ff, r_last_ff, s_last_ff, rsp_last_ff;
   logic p_free, r_free, s_free, out_free;

   logic [TAPS-1:0][PROD_W-1:0] prod_ff;
   logic [TAPS-1:0][PROD_W-1:0] prod_in;
   logic [2:0][RSUM_W-1:0]      rsum_ff;
   logic [2:0][RSUM_W-1:0]      rsum_in;
   logic [ACC_W-1:0]            acc_ff;
   logic [ACC_W-1:0]            acc_in;

   logic signed [ACC_W-1:0] shifted;
   logic signed [ACC_W:0]   mag_val;
   pixel_type               pix_in;
   pixel_type               pix_ff;

   assign kernel_all = {kernel_bottom, kernel_top_mid};

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign s_free   = !s_valid_ff || out_free;
   assign r_free   = !r_valid_ff || s_free;
   assign p_free   = !p_valid_ff || r_free;
   assign in_stall = !p_free;

   always_comb begin
      for (int t = 0; t < TAPS; t++) begin
         prod_in[t] = PROD_W'($signed(kernel_all[8*t +: 8]))
                    * PROD_W'($signed({1'b0, in_window[t]}));
      end
      for (int r = 0; r < 3; r++) begin
         rsum_in[r] = RSUM_W'($signed(prod_ff[3*r]))
                    + RSUM_W'($signed(prod_ff[3*r+1]))
                    + RSUM_W'($signed(prod_ff[3*r+2]));
      end
      acc_in = ACC_W'($signed(rsum_ff[0])) + ACC_W'($signed(rsum_ff[1]))
             + ACC_W'($signed(rsum_ff[2]));
   end

   always_comb begin
      shifted = $signed(acc_ff) >>> right_shift;
      if (magnitude_mode && shifted[ACC_W-1]) begin
         mag_val = -(ACC_W+1)'(shifted);
      end else begin
         mag_val = (ACC_W+1)'(shifted);
      end
      priority if (mag_val[ACC_W]) begin
         pix_in = '0;
      end else if (mag_val > (ACC_W+1)'(255)) begin
         pix_in = '1;
      end else begin
         pix_in = mag_val[PIX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff   <= 1'b0;
         r_valid_ff   <= 1'b0;
         s_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (p_free) begin
            p_valid_ff <= in_valid;
         end
         if (r_free) begin
            r_valid_ff <= p_valid_ff;
         end
         if (s_free) begin
            s_valid_ff <= r_valid_ff;
         end
         if (out_free) begin
            rsp_valid_ff <= s_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (p_free && in_valid) begin
         prod_ff   <= prod_in;
         p_last_ff <= in_last;
      end
      if (r_free && p_valid_ff) begin
         rsum_ff   <= rsum_in;
         r_last_ff <= p_last_ff;
      end
      if (s_free && r_valid_ff) begin
         acc_ff    <= acc_in;
         s_last_ff <= r_last_ff;
      end
      if (out_free && s_valid_ff) begin
         pix_ff      <= pix_in;
         rsp_last_ff <= s_last_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pixel_out     = pix_ff;
   assign rsp_last_of_image = rsp_last_ff;

endmodule

// File: dv/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import c3lbf_pkg::*;

   localparam int LINE_DEPTH       = 2048;
   localparam int ROW_LIMIT        = 4095;
   localparam int PIXEL_MAX        = (1 << PIX_W) - 1;
   localparam int SETTLE_CYCLES    = 12;
   localparam int HOLD_CYCLES      = 200;
   localparam int QUIET_LIMIT      = 5000;
   localparam int SEGMENT_REQUESTS = 300;
   localparam int PHASE_CAP        = 200;
   localparam int TAIL_REQUESTS    = 150;

   localparam csr_index_type CSR_SPARE_LOW  = 3'd6;
   localparam csr_index_type CSR_SPARE_HIGH = 3'd7;

   typedef struct packed {
      pixel_type pixel;
      logic      last;
   } output_pixel_type;

   class filter_scoreboard;
      logic [KTM_W-1:0]   kernel_top_mid;
      logic [KBR_W-1:0]   kernel_bottom;
      logic [SHIFT_W-1:0] shift_amount;
      logic               magnitude;
      logic [DIM_W-1:0]   height_reg;
      logic [DIM_W-1:0]   width_reg;
      int unsigned        row;
      int unsigned        column;
      pixel_type          older_line [LINE_DEPTH];
      pixel_type          newer_line [LINE_DEPTH];
      pixel_type          window [TAPS];
      output_pixel_type   awaited_pixels [$];
      int unsigned        requests;
      int unsigned        pixels_checked;
      int unsigned        images;
      int unsigned        mismatches;

      function new();
         kernel_top_mid = '0;
         kernel_bottom  = '0;
         shift_amount   = '0;
         magnitude      = 1'b0;
         height_reg     = DIM_W'(1);
         width_reg      = DIM_W'(1);
         foreach (older_line[k]) begin
            older_line[k] = '0;
            newer_line[k] = '0;
         end
         restart_scan();
         requests       = 0;
         pixels_checked = 0;
         images         = 0;
         mismatches     = 0;
      endfunction

      function void restart_scan();
         row    = 0;
         column = 0;
         foreach (window[k]) window[k] = '0;
      endfunction

      function int unsigned eff_height();
         if (height_reg == 0) return 1;
         if (height_reg > ROW_LIMIT) return ROW_LIMIT;
         return height_reg;
      endfunction

      function int unsigned eff_width();
         if (width_reg == 0) return 1;
         if (width_reg > LINE_DEPTH) return LINE_DEPTH;
         return width_reg;
      endfunction

      function int unsigned scan_length();
         return (eff_height() + 1) * (eff_width() + 1);
      endfunction

      function void configure(csr_index_type index, csr_data_type data);
         case (index)
            CSR_KERNEL_TOP_MID: kernel_top_mid = data[KTM_W-1:0];
            CSR_KERNEL_BOTTOM:  kernel_bottom  = data[KBR_W-1:0];
            CSR_RIGHT_SHIFT:    shift_amount   = data[SHIFT_W-1:0];
            CSR_MAGNITUDE:      magnitude      = data[0];
            CSR_IMAGE_HEIGHT: begin
               height_reg = data[DIM_W-1:0];
               restart_scan();
            end
            CSR_IMAGE_WIDTH: begin
               width_reg = data[DIM_W-1:0];
               restart_scan();
            end
            default: ;
         endcase
      endfunction

      function void note_request(pixel_type pixel_in);
         int unsigned       h, w, i, j, t;
         bit                in_col;
         pixel_type         fresh, upper, middle;
         logic signed [7:0] coeff;
         int                acc, level;
         output_pixel_type  result;
         h = eff_height();
         w = eff_width();
         i = (row > h) ? h : row;
         j = (column > w) ? w : column;
         in_col = (j < w);
         fresh  = (i < h && in_col) ? pixel_in : '0;
         upper  = (in_col && i >= 2) ? older_line[j] : '0;
         middle = (in_col && i >= 1) ? newer_line[j] : '0;
         if (j == 0) begin
            foreach (window[k]) window[k] = '0;
         end
         for (t = 0; t < 3; t++) begin
            window[3*t]   = window[3*t+1];
            window[3*t+1] = window[3*t+2];
         end
         window[2] = upper;
         window[5] = middle;
         window[8] = fresh;
         if (in_col) begin
            older_line[j] = middle;
            newer_line[j] = fresh;
         end
         if (i >= 1 && j >= 1) begin
            acc = 0;
            for (t = 0; t < TAPS; t++) begin
               if (t < 6) begin
                  coeff = kernel_top_mid[8*t +: 8];
               end else begin
                  coeff = kernel_bottom[8*(t-6) +: 8];
               end
               acc += int'(coeff) * int'(window[t]);
            end
            level = acc >>> shift_amount;
            if (magnitude && level < 0) level = -level;
            if (level < 0) begin
               level = 0;
            end else if (level > PIXEL_MAX) begin
               level = PIXEL_MAX;
            end
            result.pixel = level[PIX_W-1:0];
            result.last  = (i == h && j == w);
            awaited_pixels.push_back(result);
         end
         if (j >= w) begin
            column = 0;
            row    = (i >= h) ? 0 : i + 1;
         end else begin
            column = j + 1;
            row    = i;
         end
         requests++;
      endfunction

      function void check_result(pixel_type pixel_out, logic last_out);
         output_pixel_type want;
         if (awaited_pixels.size() == 0) begin
            $error("pixel_out: no output expected, got %0d (last_of_image %0b)",
                   pixel_out, last_out);
            mismatches++;
            return;
         end
         want = awaited_pixels.pop_front();
         pixels_checked++;
         if (pixel_out !== want.pixel) begin
            $error("pixel_out: expected %0d, got %0d", want.pixel, pixel_out);
            mismatches++;
         end
         if (last_out !== want.last) begin
            $error("last_of_image: expected %0b, got %0b", want.last, last_out);
            mismatches++;
         end
         if (want.last) images++;
      endfunction
   endclass

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   pixel_type     req_pixel_in = '0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   pixel_type     rsp_pixel_out;
   logic          rsp_last_of_image;
   logic          csr_write = 1'b0;
   csr_index_type csr_index = '0;
   csr_data_type  csr_wdata = '0;

   filter_scoreboard board;
   int unsigned      sender_idle_pct;
   int unsigned      receiver_idle_pct;
   int unsigned      settings_used;
   int unsigned      quiet_cycles;
   int unsigned      hold_left;
   bit               hold_wanted;

   conv3x3_line_buffer_filter_unit dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_pixel_in      (req_pixel_in),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_pixel_out     (rsp_pixel_out),
      .rsp_last_of_image (rsp_last_of_image),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         board.check_result(rsp_pixel_out, rsp_last_of_image);
      end
      if (hold_wanted) begin
         hold_wanted = 1'b0;
         hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < receiver_idle_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles == QUIET_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic send_pixel(input pixel_type pixel);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_pixel_in <= pixel;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_request(pixel);
   endtask

   task automatic write_csr(input csr_index_type index, input csr_data_type data);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      board.configure(index, data);
   endtask

   // hold the input low until every output pixel is back and the pipeline is empty
   task automatic drain_results();
      req_valid <= 1'b0;
      while (board.awaited_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic pixel_type random_pixel();
      case ($urandom_range(9))
         0:       return '0;
         1:       return pixel_type'(PIXEL_MAX);
         default: return pixel_type'($urandom_range(PIXEL_MAX));
      endcase
   endfunction

   function automatic csr_data_type kernel_pattern();
      csr_data_type value;
      value = csr_data_type'({$urandom, $urandom});
      case ($urandom_range(7))
         0:       value = {KTM_W/8{8'h80}};
         1:       value = {KTM_W/8{8'h7f}};
         default: ;
      endcase
      return value;
   endfunction

   task automatic random_phase(input bit pause_midway, input bit hold_off_first);
      csr_data_type value;
      int unsigned  length, base, k;
      drain_results();
      if ($urandom_range(9) < 7) write_csr(CSR_KERNEL_TOP_MID, kernel_pattern());
      if ($urandom_range(9) < 7) write_csr(CSR_KERNEL_BOTTOM, kernel_pattern());
      if ($urandom_range(9) < 7) begin
         value = csr_data_type'({$urandom, $urandom});
         case ($urandom_range(5))
            0:       value[SHIFT_W-1:0] = '1;
            1:       value[SHIFT_W-1:0] = '0;
            default: value[SHIFT_W-1:0] = SHIFT_W'($urandom_range(1, 12));
         endcase
         write_csr(CSR_RIGHT_SHIFT, value);
      end
      if ($urandom_range(9) < 7) begin
         write_csr(CSR_MAGNITUDE, csr_data_type'({$urandom, $urandom}));
      end
      if ($urandom_range(1) == 1) begin
         value = csr_data_type'({$urandom, $urandom});
         case ($urandom_range(9))
            0:       value[DIM_W-1:0] = '0;
            1:       value[DIM_W-1:0] = DIM_W'($urandom_range(7, 24));
            default: value[DIM_W-1:0] = DIM_W'($urandom_range(1, 6));
         endcase
         write_csr(CSR_IMAGE_HEIGHT, value);
      end
      if ($urandom_range(1) == 1) begin
         value = csr_data_type'({$urandom, $urandom});
         case ($urandom_range(9))
            0:       value[DIM_W-1:0] = '0;
            1:       value[DIM_W-1:0] = DIM_W'($urandom_range(17, 70));
            default: value[DIM_W-1:0] = DIM_W'($urandom_range(1, 16));
         endcase
         write_csr(CSR_IMAGE_WIDTH, value);
      end
      csr_write <= 1'b0;
      settings_used++;
      if (hold_off_first) hold_wanted = 1'b1;
      base   = board.scan_length();
      length = base * $urandom_range(1, 2) + $urandom_range(0, base);
      if (length > PHASE_CAP) length = $urandom_range(PHASE_CAP / 2, PHASE_CAP);
      for (k = 0; k < length; k++) begin
         if (pause_midway && k == length / 2) drain_results();
         send_pixel(random_pixel());
      end
   endtask

   initial begin
      pixel_type   pattern [$];
      int unsigned segment, segment_start;
      bit          first;
      board             = new();
      settings_used     = 0;
      quiet_cycles      = 0;
      hold_left         = 0;
      hold_wanted       = 1'b0;
      sender_idle_pct   = 11;
      receiver_idle_pct = 84;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // centre tap only, small image, spare indexes must be ignored
      write_csr(CSR_KERNEL_TOP_MID, 48'h0001_0000_0000);
      write_csr(CSR_KERNEL_BOTTOM, '0);
      write_csr(CSR_RIGHT_SHIFT, '0);
      write_csr(CSR_MAGNITUDE, '0);
      write_csr(CSR_IMAGE_HEIGHT, 48'd2);
      write_csr(CSR_IMAGE_WIDTH, 48'd3);
      write_csr(CSR_SPARE_LOW, '1);
      write_csr(CSR_SPARE_HIGH, '1);
      csr_write <= 1'b0;
      settings_used++;
      pattern = '{8'd0, 8'd255, 8'd1, 8'd128, 8'd254, 8'd127,
                  8'd85, 8'd170, 8'd255, 8'd255, 8'd0, 8'd255};
      foreach (pattern[k]) send_pixel(pattern[k]);
      drain_results();

      // most negative coefficients, magnitude folds the sum back up
      write_csr(CSR_KERNEL_TOP_MID, {KTM_W/8{8'h80}});
      write_csr(CSR_KERNEL_BOTTOM, {KTM_W/8{8'h80}});
      write_csr(CSR_MAGNITUDE, 48'd1);
      write_csr(CSR_IMAGE_HEIGHT, 48'd1);
      write_csr(CSR_IMAGE_WIDTH, 48'd2);
      csr_write <= 1'b0;
      settings_used++;
      repeat (6) send_pixel(8'd255);
      drain_results();

      // largest coefficients, full shift, zero geometry, the height with junk in its upper bits
      write_csr(CSR_KERNEL_TOP_MID, {KTM_W/8{8'h7f}});
      write_csr(CSR_KERNEL_BOTTOM, {KTM_W/8{8'h7f}});
      write_csr(CSR_RIGHT_SHIFT, '1);
      write_csr(CSR_MAGNITUDE, 48'hffff_ffff_fffe);
      write_csr(CSR_IMAGE_HEIGHT, 48'hffff_ffff_f000);
      write_csr(CSR_IMAGE_WIDTH, '0);
      csr_write <= 1'b0;
      settings_used++;
      repeat (4) send_pixel(8'd255);

      for (segment = 0; segment < 3; segment++) begin
         case (segment)
            0: begin
               sender_idle_pct   = 11;
               receiver_idle_pct = 84;
            end
            1: begin
               sender_idle_pct   = 84;
               receiver_idle_pct = 11;
            end
            default: begin
               sender_idle_pct   = 0;
               receiver_idle_pct = 0;
            end
         endcase
         segment_start = board.requests;
         first         = 1'b1;
         while (board.requests - segment_start < SEGMENT_REQUESTS) begin
            random_phase(first, first && segment == 2);
            first = 1'b0;
         end
      end

      // start of the tallest image on a single column, then of one wider than the store
      drain_results();
      write_csr(CSR_IMAGE_HEIGHT, csr_data_type'(ROW_LIMIT));
      write_csr(CSR_IMAGE_WIDTH, '0);
      csr_write <= 1'b0;
      settings_used++;
      repeat (TAIL_REQUESTS) send_pixel(random_pixel());
      drain_results();
      write_csr(CSR_IMAGE_HEIGHT, 48'd1);
      write_csr(CSR_IMAGE_WIDTH, csr_data_type'({DIM_W{1'b1}}));
      csr_write <= 1'b0;
      settings_used++;
      repeat (TAIL_REQUESTS) send_pixel(random_pixel());
      drain_results();

      $display("Run covered %0d requests, %0d checked output pixels and %0d whole images",
               board.requests, board.pixels_checked, board.images);
      $display("over %0d filter settings, with scans begun at %0d rows and an oversized width.",
               settings_used, ROW_LIMIT);
      if (board.mismatches == 0 && board.awaited_pixels.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
